FILE: design/tdpd_pkg.sv
// ----------------------------------------------------------------------------
// tdpd_pkg
// Shared sizes, codes and controller/datapath interface types for the
// two-direction priority dispatch core.
// ----------------------------------------------------------------------------
package tdpd_pkg;

	localparam int QUEUE_DEPTH = 128;
	localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int ID_W        = 7;
	localparam int ENTRY_W     = ID_W + 1;
	localparam int LIMIT_W     = 4;
	localparam int DIR_W       = 2;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd2;
	localparam logic [LIMIT_W-1:0] RUN_MAX     = 4'd15;

	// Last grant direction codes.
	localparam logic [DIR_W-1:0] DIR_WEST = 2'd0;
	localparam logic [DIR_W-1:0] DIR_EAST = 2'd1;
	localparam logic [DIR_W-1:0] DIR_NONE = 2'd2;

	localparam logic KIND_ARRIVE   = 1'b0;
	localparam logic KIND_DISPATCH = 1'b1;

	typedef struct packed {
		logic capture;
		logic arrive;
		logic scan_run;
		logic decide;
		logic shift_run;
		logic finish_load;
	} cmd_t;

	typedef struct packed {
		logic in_is_dispatch;
		logic scan_done;
		logic will_grant;
		logic shift_done;
		logic out_free;
	} sts_t;

endpackage

FILE: design/tdpd_ram.sv
// ----------------------------------------------------------------------------
// tdpd_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module tdpd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: design/tdpd_ctrl.sv
// ----------------------------------------------------------------------------
// tdpd_ctrl
// Sequencing state machine: accept, enqueue or scan/decide/compact, deliver.
// ----------------------------------------------------------------------------
module tdpd_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  tdpd_pkg::sts_t sts,
	output tdpd_pkg::cmd_t cmd
);
	import tdpd_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_ARRIVE = 3'd1;
	localparam logic [2:0] S_SCAN   = 3'd2;
	localparam logic [2:0] S_DECIDE = 3'd3;
	localparam logic [2:0] S_SHIFT  = 3'd4;
	localparam logic [2:0] S_FINISH = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d = sts.in_is_dispatch ? S_SCAN : S_ARRIVE;
				end
			end
			S_ARRIVE: begin
				cmd.arrive = 1'b1;
				state_d = S_FINISH;
			end
			S_SCAN: begin
				cmd.scan_run = 1'b1;
				if (sts.scan_done) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				cmd.decide = 1'b1;
				state_d = sts.will_grant ? S_SHIFT : S_FINISH;
			end
			S_SHIFT: begin
				cmd.shift_run = 1'b1;
				if (sts.shift_done) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				if (sts.out_free) begin
					cmd.finish_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: design/tdpd_datapath.sv
// ----------------------------------------------------------------------------
// tdpd_datapath
// Queue RAMs, counts, scan trackers, grant decision, compaction and the
// output register. Index 0 of each per-direction array is west, 1 is east.
// ----------------------------------------------------------------------------
module tdpd_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tdpd_pkg::cmd_t                cmd,
	output tdpd_pkg::sts_t                sts,
	input  logic                          kind,
	input  logic [tdpd_pkg::ID_W-1:0]     requester_id,
	input  logic                          going_east,
	input  logic                          urgent,
	input  logic                          cfg_wr_en,
	input  logic [tdpd_pkg::LIMIT_W-1:0]  cfg_wr_data,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic                          granted,
	output logic [tdpd_pkg::ID_W-1:0]     granted_id,
	output logic                          granted_east,
	output logic                          arrival_dropped
);
	import tdpd_pkg::*;

	localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

	// Captured item.
	logic [ID_W-1:0] id_q;
	logic            east_q;
	logic            hp_q;

	logic [LIMIT_W-1:0] limit_q;
	logic [DIR_W-1:0]   last_q;
	logic [LIMIT_W-1:0] run_q;
	logic [CNT_W-1:0]   cnt_q [2];

	// Scan trackers.
	logic [CNT_W-1:0]  scan_idx_q;
	logic              rd_valid_s1;
	logic [CNT_W-1:0]  rd_idx_s1;
	logic [1:0]        hp_found_q;
	logic [1:0]        lp_found_q;
	logic [ADDR_W-1:0] hp_pos_q [2];
	logic [ADDR_W-1:0] lp_pos_q [2];
	logic [ID_W-1:0]   hp_id_q [2];
	logic [ID_W-1:0]   lp_id_q [2];
	logic [ID_W-1:0]   head_id_q [2];

	// Compaction.
	logic             gdir_q;
	logic [CNT_W-1:0] sh_q;
	logic             sh_valid_s1;
	logic [CNT_W-1:0] sh_idx_s1;

	// Pending result and output register.
	logic            res_granted_q;
	logic [ID_W-1:0] res_id_q;
	logic            res_east_q;
	logic            res_dropped_q;
	logic            out_valid_q;
	logic            out_granted_q;
	logic [ID_W-1:0] out_id_q;
	logic            out_east_q;
	logic            out_dropped_q;

	// RAM ports.
	logic [ENTRY_W-1:0] rdata [2];
	logic [1:0]         ram_we;
	logic [ADDR_W-1:0]  ram_waddr [2];
	logic [ENTRY_W-1:0] ram_wdata [2];
	logic [ADDR_W-1:0]  ram_raddr;

	logic [CNT_W-1:0] scan_len;
	logic             scan_issue;
	logic             sh_issue;
	logic             arr_full;

	// Decision.
	logic              forced;
	logic              opp;
	logic              tie;
	logic              sel_found;
	logic              sel_dir;
	logic [ADDR_W-1:0] sel_pos;
	logic [ID_W-1:0]   sel_id;

	assign scan_len   = (cnt_q[1] > cnt_q[0]) ? cnt_q[1] : cnt_q[0];
	assign scan_issue = scan_idx_q < scan_len;
	assign sh_issue   = sh_q < cnt_q[gdir_q];
	assign arr_full   = cnt_q[east_q] == CNT_FULL;
	assign ram_raddr  = cmd.shift_run ? sh_q[ADDR_W-1:0] : scan_idx_q[ADDR_W-1:0];

	always_comb begin
		for (int d = 0; d < 2; d++) begin
			if (cmd.shift_run) begin
				ram_we[d]    = sh_valid_s1 && (gdir_q == 1'(d));
				ram_waddr[d] = ADDR_W'(sh_idx_s1 - CNT_ONE);
				ram_wdata[d] = rdata[d];
			end else begin
				ram_we[d]    = cmd.arrive && !arr_full && (east_q == 1'(d));
				ram_waddr[d] = cnt_q[d][ADDR_W-1:0];
				ram_wdata[d] = {hp_q, id_q};
			end
		end
	end

	tdpd_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_west_ram (
		.clk   (clk),
		.we    (ram_we[0]),
		.waddr (ram_waddr[0]),
		.wdata (ram_wdata[0]),
		.raddr (ram_raddr),
		.rdata (rdata[0])
	);

	tdpd_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_east_ram (
		.clk   (clk),
		.we    (ram_we[1]),
		.waddr (ram_waddr[1]),
		.wdata (ram_wdata[1]),
		.raddr (ram_raddr),
		.rdata (rdata[1])
	);

	// Grant choice from the scan results.
	always_comb begin
		forced    = (last_q != DIR_NONE) && (run_q >= limit_q);
		opp       = (last_q != DIR_EAST);
		tie       = (last_q == DIR_WEST);
		sel_found = 1'b1;
		sel_dir   = 1'b0;
		sel_pos   = '0;
		sel_id    = '0;
		if (forced && (cnt_q[opp] != '0)) begin
			sel_dir = opp;
			sel_id  = head_id_q[opp];
		end else if (hp_found_q == 2'b11) begin
			sel_dir = tie;
			sel_pos = hp_pos_q[tie];
			sel_id  = hp_id_q[tie];
		end else if (hp_found_q != 2'b00) begin
			sel_dir = hp_found_q[1];
			sel_pos = hp_pos_q[hp_found_q[1]];
			sel_id  = hp_id_q[hp_found_q[1]];
		end else if (lp_found_q == 2'b11) begin
			sel_dir = tie;
			sel_pos = lp_pos_q[tie];
			sel_id  = lp_id_q[tie];
		end else if (lp_found_q != 2'b00) begin
			sel_dir = lp_found_q[1];
			sel_pos = lp_pos_q[lp_found_q[1]];
			sel_id  = lp_id_q[lp_found_q[1]];
		end else begin
			sel_found = 1'b0;
		end
	end

	assign sts.in_is_dispatch = (kind == KIND_DISPATCH);
	assign sts.scan_done      = !scan_issue && !rd_valid_s1;
	assign sts.will_grant     = sel_found;
	assign sts.shift_done     = !sh_issue && !sh_valid_s1;
	assign sts.out_free       = !out_valid_q || out_ready;

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			id_q   <= requester_id;
			east_q <= going_east;
			hp_q   <= urgent;
		end
		if (cmd.arrive) begin
			res_granted_q <= 1'b0;
			res_id_q      <= '0;
			res_east_q    <= 1'b0;
			res_dropped_q <= arr_full;
		end
		if (cmd.decide) begin
			res_granted_q <= sel_found;
			res_id_q      <= sel_found ? sel_id : '0;
			res_east_q    <= sel_found && sel_dir;
			res_dropped_q <= 1'b0;
			gdir_q        <= sel_dir;
		end
		if (cmd.finish_load) begin
			out_granted_q <= res_granted_q;
			out_id_q      <= res_id_q;
			out_east_q    <= res_east_q;
			out_dropped_q <= res_dropped_q;
		end
		rd_idx_s1 <= scan_idx_q;
		sh_idx_s1 <= sh_q;
		if (rd_valid_s1) begin
			for (int d = 0; d < 2; d++) begin
				if (rd_idx_s1 < cnt_q[d]) begin
					if (rd_idx_s1 == '0) begin
						head_id_q[d] <= rdata[d][ID_W-1:0];
					end
					if (rdata[d][ENTRY_W-1] && !hp_found_q[d]) begin
						hp_pos_q[d] <= rd_idx_s1[ADDR_W-1:0];
						hp_id_q[d]  <= rdata[d][ID_W-1:0];
					end
					if (!rdata[d][ENTRY_W-1] && !lp_found_q[d]) begin
						lp_pos_q[d] <= rd_idx_s1[ADDR_W-1:0];
						lp_id_q[d]  <= rdata[d][ID_W-1:0];
					end
				end
			end
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q     <= LIMIT_RESET;
			last_q      <= DIR_NONE;
			run_q       <= '0;
			cnt_q[0]    <= '0;
			cnt_q[1]    <= '0;
			scan_idx_q  <= '0;
			rd_valid_s1 <= 1'b0;
			hp_found_q  <= '0;
			lp_found_q  <= '0;
			sh_q        <= '0;
			sh_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				limit_q <= cfg_wr_data;
			end
			if (cmd.capture) begin
				scan_idx_q <= '0;
				hp_found_q <= '0;
				lp_found_q <= '0;
			end
			if (cmd.arrive && !arr_full) begin
				cnt_q[east_q] <= cnt_q[east_q] + CNT_ONE;
			end
			rd_valid_s1 <= cmd.scan_run && scan_issue;
			if (cmd.scan_run && scan_issue) begin
				scan_idx_q <= scan_idx_q + CNT_ONE;
			end
			if (rd_valid_s1) begin
				for (int d = 0; d < 2; d++) begin
					if (rd_idx_s1 < cnt_q[d]) begin
						if (rdata[d][ENTRY_W-1]) begin
							hp_found_q[d] <= 1'b1;
						end else begin
							lp_found_q[d] <= 1'b1;
						end
					end
				end
			end
			if (cmd.decide && sel_found) begin
				sh_q <= CNT_W'(sel_pos) + CNT_ONE;
				if (last_q == {1'b0, sel_dir}) begin
					if (run_q != RUN_MAX) begin
						run_q <= run_q + LIMIT_W'(1);
					end
				end else begin
					last_q <= {1'b0, sel_dir};
					run_q  <= LIMIT_W'(1);
				end
			end
			sh_valid_s1 <= cmd.shift_run && sh_issue;
			if (cmd.shift_run && sh_issue) begin
				sh_q <= sh_q + CNT_ONE;
			end
			if (cmd.shift_run && !sh_issue && !sh_valid_s1) begin
				cnt_q[gdir_q] <= cnt_q[gdir_q] - CNT_ONE;
			end
			if (cmd.finish_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign granted         = out_granted_q;
	assign granted_id      = out_id_q;
	assign granted_east    = out_east_q;
	assign arrival_dropped = out_dropped_q;

endmodule

FILE: design/two_direction_priority_dispatch_core.sv
// ----------------------------------------------------------------------------
// two_direction_priority_dispatch_core
// Dispatcher with one arrival-ordered queue per direction and a run limit.
// ----------------------------------------------------------------------------
// An arrive item is enqueued and its result is loaded into the output register.
// A dispatch item scans both queues up to the longer of the west and east counts,
// takes the decision, compacts the granted queue behind the granted entry when
// there is a grant, and then loads the output register. Items are handled one
// at a time: the controller accepts a new item only in its idle state.
// Reset sets the limit to 2.
// ----------------------------------------------------------------------------
module two_direction_priority_dispatch_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          kind,
	input  logic [tdpd_pkg::ID_W-1:0]     requester_id,
	input  logic                          going_east,
	input  logic                          urgent,
	input  logic                          cfg_wr_en,
	input  logic [tdpd_pkg::LIMIT_W-1:0]  cfg_wr_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          granted,
	output logic [tdpd_pkg::ID_W-1:0]     granted_id,
	output logic                          granted_east,
	output logic                          arrival_dropped
);
	import tdpd_pkg::*;

	// The controller only sequences; every piece of state that the behavior
	// depends on (queues, counts, last direction, run counter, limit) lives
	// in the datapath. Reset empties both queues and clears the run state.
	cmd_t cmd;
	sts_t sts;

	tdpd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// The datapath scans both queues in parallel, one entry per cycle, to
	// find the first high and low priority entries and each head. After the
	// decision the granted queue is compacted by reading entry i + 1 and
	// writing it back to entry i in the next cycle. The output register lets
	// the next item be accepted while a result still waits to be taken.
	tdpd_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.kind            (kind),
		.requester_id    (requester_id),
		.going_east      (going_east),
		.urgent          (urgent),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.out_ready       (out_ready),
		.out_valid       (out_valid),
		.granted         (granted),
		.granted_id      (granted_id),
		.granted_east    (granted_east),
		.arrival_dropped (arrival_dropped)
	);

endmodule

FILE: design/tdpd_checker.sv
// ----------------------------------------------------------------------------
// tdpd_checker
// Port-level assertions for the dispatch core, attached by a bind.
// ----------------------------------------------------------------------------
module tdpd_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic                          granted,
	input  logic [tdpd_pkg::ID_W-1:0]     granted_id,
	input  logic                          granted_east,
	input  logic                          arrival_dropped
);
	import tdpd_pkg::*;

	// A stalled result holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(granted) &&
		$stable(granted_id) && $stable(granted_east) && $stable(arrival_dropped))
		else $error("result changed while stalled");

	// A result never reports both a grant and a dropped arrival.
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(granted && arrival_dropped))
		else $error("grant and drop in one result");

	// Without a grant the id and direction read as zero.
	a_no_grant_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !granted |-> (granted_id == '0) && !granted_east)
		else $error("nonzero grant fields without a grant");

	// An accepted item keeps the block busy in the next cycle.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item accepted while previous item in flight");

endmodule

bind two_direction_priority_dispatch_core tdpd_checker u_tdpd_checker (.*);

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the two-direction priority dispatch core. Arrive
// and dispatch items go in over a valid/ready channel with random pacing.
// A local predictor keeps its own copy of both direction queues and of the
// run state. Every result is compared field by field, in order, with what
// the predictor worked out when the item was accepted.
// ----------------------------------------------------------------------------
module tb_top;

	import tdpd_pkg::*;

	// Watchdog limit. A correct run needs well under a quarter of that,
	// even with every dispatch scanning full queues and every gap at its longest.
	localparam longint RUN_LIMIT_NS     = 64'd40_000_000;
	// The receiver refuses results for this many cycles every 400 results.
	localparam int     SINK_HOLD_CYCLES = 300;

	// One item on the input side and one result on the output side.
	typedef struct {
		logic            kind;
		logic [ID_W-1:0] id;
		logic            east;
		logic            hp;
	} request_t;

	typedef struct {
		logic            granted;
		logic [ID_W-1:0] id;
		logic            east;
		logic            dropped;
	} outcome_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic                kind = KIND_ARRIVE;
	logic [ID_W-1:0]     requester_id = '0;
	logic                going_east = 1'b0;
	logic                urgent = 1'b0;
	logic                cfg_wr_en = 1'b0;
	logic [LIMIT_W-1:0]  cfg_wr_data = LIMIT_RESET;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic                granted;
	logic [ID_W-1:0]     granted_id;
	logic                granted_east;
	logic                arrival_dropped;

	two_direction_priority_dispatch_core dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.kind            (kind),
		.requester_id    (requester_id),
		.going_east      (going_east),
		.urgent          (urgent),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.granted         (granted),
		.granted_id      (granted_id),
		.granted_east    (granted_east),
		.arrival_dropped (arrival_dropped)
	);

	always #10 clk = ~clk;

	// Items waiting to be offered, and results the block still owes us.
	request_t requests_to_send[$];
	outcome_t expected_outcomes[$];

	// Predictor state. The queues are indexed by direction code, so west is
	// lane 0 and east is lane 1. Each entry is {priority, id}.
	logic [ENTRY_W-1:0] lane_q [2][QUEUE_DEPTH];
	int                 lane_n [2];
	logic [DIR_W-1:0]   prev_grant_dir;
	logic [LIMIT_W-1:0] run_len;
	logic [LIMIT_W-1:0] run_limit;

	// Statistics and bookkeeping.
	int  failures;
	int  n_arrivals, n_dispatches, n_grants, n_drops, n_idle_dispatches, n_forced;
	int  n_sink_holds;
	int  send_gap;
	int  sink_stall;
	int  sink_taken;
	bit  no_idle;
	logic [LIMIT_W-1:0] random_limit;

	// Gap lengths: mostly none or short, now and then a long one. Phases that
	// set no_idle run both sides flat out.
	function automatic int idle_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Position of the first entry of a priority class in one lane, or -1.
	function automatic int first_of_class(input logic lane, input logic cls);
		for (int i = 0; i < lane_n[lane]; i++)
			if (lane_q[lane][i][ID_W] == cls)
				return i;
		return -1;
	endfunction

	// Applies one accepted item to the predictor and returns the result the
	// block must produce for it.
	task automatic resolve_request(input request_t rq, output outcome_t res);
		logic [DIR_W-1:0] tie_dir;
		logic [DIR_W-1:0] pick_dir;
		logic             lane;
		int               pos, pe, pw;
		bit               found;
		res = '{granted: 1'b0, id: '0, east: 1'b0, dropped: 1'b0};
		if (rq.kind == KIND_ARRIVE) begin
			n_arrivals++;
			lane = rq.east;
			if (lane_n[lane] >= QUEUE_DEPTH) begin
				// A full lane drops the arrival and keeps its contents.
				res.dropped = 1'b1;
				n_drops++;
			end else begin
				lane_q[lane][lane_n[lane]] = {rq.hp, rq.id};
				lane_n[lane]++;
			end
			return;
		end
		n_dispatches++;
		found = 1'b0;
		pos = 0;
		pick_dir = DIR_WEST;
		// On a tie the side opposite the last grant wins; before any grant, west.
		tie_dir = (prev_grant_dir == DIR_WEST) ? DIR_EAST : DIR_WEST;
		// A run that reached the limit hands the resource to the other side's
		// head, unless that side has nobody waiting.
		if (prev_grant_dir != DIR_NONE && run_len >= run_limit) begin
			pick_dir = (prev_grant_dir == DIR_EAST) ? DIR_WEST : DIR_EAST;
			if (lane_n[pick_dir[0]] > 0) begin
				found = 1'b1;
				n_forced++;
			end
		end
		// Otherwise high priority first, then low, oldest entry of the class.
		for (int cls = 1; cls >= 0 && !found; cls--) begin
			pe = first_of_class(1'b1, cls[0]);
			pw = first_of_class(1'b0, cls[0]);
			if (pe >= 0 && pw >= 0) begin
				pick_dir = tie_dir;
				pos = (tie_dir == DIR_EAST) ? pe : pw;
				found = 1'b1;
			end else if (pe >= 0) begin
				pick_dir = DIR_EAST;
				pos = pe;
				found = 1'b1;
			end else if (pw >= 0) begin
				pick_dir = DIR_WEST;
				pos = pw;
				found = 1'b1;
			end
		end
		if (!found) begin
			n_idle_dispatches++;
			return;
		end
		lane = pick_dir[0];
		res.id = lane_q[lane][pos][ID_W-1:0];
		// Remove exactly the chosen slot, so duplicate ids further back stay.
		for (int i = pos; i + 1 < lane_n[lane]; i++)
			lane_q[lane][i] = lane_q[lane][i + 1];
		lane_n[lane]--;
		if (prev_grant_dir == pick_dir) begin
			if (run_len < RUN_MAX)
				run_len++;
		end else begin
			prev_grant_dir = pick_dir;
			run_len = LIMIT_W'(1);
		end
		res.granted = 1'b1;
		res.east = (pick_dir == DIR_EAST);
		n_grants++;
	endtask

	function automatic void post_request(input logic k, input int id, input logic east,
			input logic hp);
		request_t rq;
		rq.kind = k;
		rq.id = id[ID_W-1:0];
		rq.east = east;
		rq.hp = hp;
		requests_to_send.push_back(rq);
	endfunction

	// Random traffic that keeps the queues shallow most of the time, so that
	// dispatch scans stay short. A quarter of the ids come from a tiny set to
	// produce duplicate ids within a lane.
	task automatic queue_mix(input int count);
		int   depth_guess;
		logic k;
		depth_guess = lane_n[0] + lane_n[1];
		repeat (count) begin
			if (depth_guess == 0)
				k = ($urandom_range(0, 9) == 0) ? KIND_DISPATCH : KIND_ARRIVE;
			else
				k = ($urandom_range(0, 99) < (depth_guess > 8 ? 70 : 40)) ?
					KIND_DISPATCH : KIND_ARRIVE;
			if (k == KIND_ARRIVE)
				depth_guess++;
			else if (depth_guess > 0)
				depth_guess--;
			post_request(k,
				($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : $urandom_range(0, 127),
				1'($urandom_range(0, 1)), $urandom_range(0, 2) == 0);
		end
	endtask

	// Fills one lane past its depth so the last arrivals are dropped, with a
	// few entries on the other side, then posts two dispatches more than the
	// entries that the burst can add.
	task automatic queue_fill_burst(input logic lane);
		repeat (4)
			post_request(KIND_ARRIVE, $urandom_range(0, 127), !lane,
				1'($urandom_range(0, 1)));
		repeat (QUEUE_DEPTH + 3)
			post_request(KIND_ARRIVE, $urandom_range(0, 127), lane, $urandom_range(0, 3) == 0);
		repeat (QUEUE_DEPTH + 6)
			post_request(KIND_DISPATCH, $urandom_range(0, 127), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)));
	endtask

	// Holds the sender back until everything offered has come back out.
	task automatic wait_drained();
		do
			@(negedge clk);
		while (requests_to_send.size() != 0 || in_valid || expected_outcomes.size() != 0);
	endtask

	// The limit register may only change while nothing is in flight.
	task automatic write_limit(input logic [LIMIT_W-1:0] value);
		wait_drained();
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		run_limit = value;
	endtask

	// Sender: offers the next queued item once the previous one is taken and
	// its gap has run out. Valid is computed first and assigned once, so a
	// back-to-back item keeps it high through the edge.
	always @(posedge clk) begin : request_driver
		logic     offering;
		outcome_t res;
		request_t rq;
		offering = in_valid;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				rq.kind = kind;
				rq.id = requester_id;
				rq.east = going_east;
				rq.hp = urgent;
				resolve_request(rq, res);
				expected_outcomes.push_back(res);
				offering = 1'b0;
				send_gap = idle_gap();
			end
			if (!offering) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (requests_to_send.size() != 0) begin
					rq = requests_to_send.pop_front();
					kind          <= rq.kind;
					requester_id  <= rq.id;
					going_east    <= rq.east;
					urgent        <= rq.hp;
					offering = 1'b1;
				end
			end
			in_valid <= offering;
		end
	end

	// Receiver pacing. It counts the results it takes, and every 400 results
	// it refuses output for a long stretch so that the core backs up and
	// stops taking input while the sender is still offering.
	always @(posedge clk) begin : sink_pacing
		logic rdy;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				sink_taken++;
				if (sink_taken % 400 == 200) begin
					sink_stall = SINK_HOLD_CYCLES;
					n_sink_holds++;
				end else begin
					sink_stall = idle_gap();
				end
			end else if (sink_stall == 0 && !no_idle && $urandom_range(0, 19) == 0) begin
				sink_stall = idle_gap();
			end
			if (sink_stall > 0) begin
				sink_stall--;
				rdy = 1'b0;
			end else begin
				rdy = 1'b1;
			end
			out_ready <= rdy;
		end
	end

	// Checker: each result taken is matched against the oldest expectation.
	always @(posedge clk) begin : outcome_checker
		outcome_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_outcomes.size() == 0) begin
				$error("result with nothing expected: granted %0d id %0d east %0d dropped %0d",
					granted, granted_id, granted_east, arrival_dropped);
				failures++;
			end else begin
				want = expected_outcomes.pop_front();
				if (granted !== want.granted) begin
					$error("granted: expected %0d, got %0d", want.granted, granted);
					failures++;
				end
				if (granted_id !== want.id) begin
					$error("granted_id: expected %0d, got %0d", want.id, granted_id);
					failures++;
				end
				if (granted_east !== want.east) begin
					$error("granted_east: expected %0d, got %0d", want.east, granted_east);
					failures++;
				end
				if (arrival_dropped !== want.dropped) begin
					$error("arrival_dropped: expected %0d, got %0d", want.dropped,
						arrival_dropped);
					failures++;
				end
			end
		end
	end

	// Watchdog for a hung handshake.
	initial begin
		#(RUN_LIMIT_NS);
		$display("tb: failure");
		$finish;
	end

	initial begin
		// Predictor starts where reset leaves the core: empty lanes, no grant
		// yet, limit at its reset value.
		lane_n[0] = 0;
		lane_n[1] = 0;
		prev_grant_dir = DIR_NONE;
		run_len = '0;
		run_limit = LIMIT_RESET;
		failures = 0;
		send_gap = 0;
		sink_stall = 0;
		sink_taken = 0;
		no_idle = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed opening at the reset limit. A dispatch with nothing queued,
		// then one entry per side at the id extremes, settled by the west-first
		// tie break and then by alternation.
		post_request(KIND_DISPATCH, 127, 1'b1, 1'b1);
		post_request(KIND_ARRIVE, 0, 1'b0, 1'b0);
		post_request(KIND_ARRIVE, 127, 1'b1, 1'b0);
		post_request(KIND_DISPATCH, 0, 1'b0, 1'b0);
		post_request(KIND_DISPATCH, 0, 1'b0, 1'b0);
		post_request(KIND_DISPATCH, 0, 1'b0, 1'b0);
		// High priority behind low priority, a duplicate id in the east lane,
		// and a run of two east grants that forces the west head next.
		post_request(KIND_ARRIVE, 10, 1'b0, 1'b0);
		post_request(KIND_ARRIVE, 11, 1'b0, 1'b1);
		post_request(KIND_ARRIVE, 12, 1'b1, 1'b1);
		post_request(KIND_ARRIVE, 12, 1'b1, 1'b0);
		post_request(KIND_ARRIVE, 127, 1'b1, 1'b1);
		repeat (6)
			post_request(KIND_DISPATCH, 85, 1'b1, 1'b1);
		// The run limit is reached with the other lane empty, so the normal
		// choice keeps granting east.
		post_request(KIND_ARRIVE, 1, 1'b1, 1'b0);
		post_request(KIND_ARRIVE, 2, 1'b1, 1'b1);
		post_request(KIND_ARRIVE, 3, 1'b1, 1'b0);
		repeat (3)
			post_request(KIND_DISPATCH, 42, 1'b0, 1'b0);
		queue_mix(200);

		// A limit of zero forces the other head after every grant, unless that lane is empty.
		write_limit(4'd0);
		queue_mix(200);

		// Highest limit with a west lane filled past full, both sides at speed.
		write_limit(4'd15);
		no_idle = 1'b1;
		queue_fill_burst(1'b0);

		// A limit of 1 with the east lane overflowing, paced again.
		write_limit(4'd1);
		wait_drained();
		no_idle = 1'b0;
		queue_fill_burst(1'b1);

		write_limit(4'd3);
		queue_mix(150);

		random_limit = LIMIT_W'($urandom_range(1, 14));
		write_limit(random_limit);
		queue_mix(150);

		// Everything offered has been answered; leave room for a stray result.
		wait_drained();
		repeat (2 * QUEUE_DEPTH + 8) @(posedge clk);

		$display("Covered %0d arrivals (%0d dropped on a full lane) and %0d dispatches",
			n_arrivals, n_drops, n_dispatches);
		$display("with %0d grants, %0d forced, %0d empty; limits 2, 0, 15, 1, 3, %0d; %0d long holds",
			n_grants, n_forced, n_idle_dispatches, random_limit, n_sink_holds);
		if (failures == 0 && expected_outcomes.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
